>>> design/efe_pkg.sv
package efe_pkg;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // configuration register indexes
    localparam logic [1:0] CFG_START  = 2'd0;
    localparam logic [1:0] CFG_STOP   = 2'd1;
    localparam logic [1:0] CFG_ESCAPE = 2'd2;

    // reset values of the framing codes
    localparam logic [7:0] START_RST  = 8'd125;
    localparam logic [7:0] STOP_RST   = 8'd126;
    localparam logic [7:0] ESCAPE_RST = 8'd127;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] stop_code;
        logic [7:0] escape_code;
    } t_codes;

    // one classified input word, as handed from front to back
    typedef struct packed {
        logic [7:0] data;    // byte as received
        logic       esc_b;   // byte needs an escape prefix
        logic       last;    // trailer follows
        logic [7:0] cks;     // checksum including this byte
        logic       esc_c;   // checksum needs an escape prefix
    } t_cmd;

    // queue status seen by the other modules
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic is_special(input logic [7:0] b, input t_codes c);
        return (b == c.start_code) || (b == c.stop_code) || (b == c.escape_code);
    endfunction

endpackage

>>> design/efe_front.sv
module efe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_frame_last,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    output efe_pkg::t_cmd     o_cmd,
    output efe_pkg::t_codes   o_codes
);

    efe_pkg::t_codes r_codes;
    logic [7:0]      r_cks;
    logic            r_at_start;
    logic [7:0]      n_cks;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.start_code  <= efe_pkg::START_RST;
            r_codes.stop_code   <= efe_pkg::STOP_RST;
            r_codes.escape_code <= efe_pkg::ESCAPE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                efe_pkg::CFG_START:  r_codes.start_code  <= i_cfg_data;
                efe_pkg::CFG_STOP:   r_codes.stop_code   <= i_cfg_data;
                efe_pkg::CFG_ESCAPE: r_codes.escape_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // classify the incoming word
    always_comb begin
        n_cks       = r_cks ^ i_data_byte;
        o_cmd.data  = i_data_byte;
        o_cmd.esc_b = !r_at_start && efe_pkg::is_special(i_data_byte, r_codes);
        o_cmd.last  = i_frame_last;
        o_cmd.cks   = n_cks;
        o_cmd.esc_c = efe_pkg::is_special(n_cks, r_codes);
    end

    // running checksum and frame-start flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cks      <= 8'd0;
            r_at_start <= 1'b1;
        end else if (i_accept) begin
            r_cks      <= i_frame_last ? 8'd0 : n_cks;
            r_at_start <= i_frame_last;
        end
    end

    assign o_codes = r_codes;

endmodule

>>> design/efe_queue.sv
module efe_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  efe_pkg::t_cmd     i_cmd,
    input  logic              i_rd,
    output efe_pkg::t_cmd     o_head,
    output efe_pkg::t_qstat   o_stat
);

    efe_pkg::t_cmd            r_mem [efe_pkg::QDEPTH];
    logic [efe_pkg::QAW-1:0]  r_wr_ptr;
    logic [efe_pkg::QAW-1:0]  r_rd_ptr;
    logic [efe_pkg::QAW:0]    r_count;

    // storage, no reset on payload
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == (efe_pkg::QAW+1)'(efe_pkg::QDEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

>>> design/efe_back.sv
module efe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  efe_pkg::t_cmd     i_head,
    input  efe_pkg::t_qstat   i_qstat,
    input  efe_pkg::t_codes   i_codes,
    output logic              o_q_rd,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [7:0]        o_line_byte,
    output logic              o_run_last,
    output logic              o_frame_end
);

    typedef enum logic [4:0] {
        ST_HEAD = 5'b00001,  // first word of the queue head
        ST_BYTE = 5'b00010,  // data byte after its escape
        ST_CESC = 5'b00100,  // escape before checksum
        ST_CKS  = 5'b01000,  // checksum
        ST_STOP = 5'b10000   // stop code
    } t_state;

    t_state     r_state, n_state;
    logic       r_out_valid;
    logic [7:0] r_line;
    logic       r_run_last;
    logic       r_frame_end;

    logic [7:0] w_byte;
    logic       w_last;
    logic       w_end;
    logic       w_done;
    logic       emit_byte;
    logic       advance;

    // a word waits and the output register is free or being drained this cycle
    assign advance = !i_qstat.empty && (!r_out_valid || i_pop);

    // word selection for the current step of the head entry
    always_comb begin
        w_byte    = i_head.data;
        w_last    = 1'b0;
        w_end     = 1'b0;
        w_done    = 1'b0;
        emit_byte = 1'b0;
        n_state   = r_state;
        case (r_state)
            ST_HEAD: begin
                if (i_head.esc_b) begin
                    w_byte  = i_codes.escape_code;
                    n_state = ST_BYTE;
                end else begin
                    emit_byte = 1'b1;
                end
            end
            ST_BYTE: emit_byte = 1'b1;
            ST_CESC: begin
                w_byte  = i_codes.escape_code;
                n_state = ST_CKS;
            end
            ST_CKS: begin
                w_byte  = i_head.cks;
                n_state = ST_STOP;
            end
            ST_STOP: begin
                w_byte  = i_codes.stop_code;
                w_last  = 1'b1;
                w_end   = 1'b1;
                w_done  = 1'b1;
                n_state = ST_HEAD;
            end
            default: n_state = ST_HEAD;
        endcase
        if (emit_byte) begin
            w_byte = i_head.data;
            if (i_head.last) begin
                n_state = i_head.esc_c ? ST_CESC : ST_CKS;
            end else begin
                w_last  = 1'b1;
                w_done  = 1'b1;
                n_state = ST_HEAD;
            end
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HEAD;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_line      <= w_byte;
            r_run_last  <= w_last;
            r_frame_end <= w_end;
        end
    end

    assign o_q_rd      = advance && w_done;
    assign o_empty     = !r_out_valid;
    assign o_line_byte = r_line;
    assign o_run_last  = r_run_last;
    assign o_frame_end = r_frame_end;

endmodule

>>> design/escaped_frame_encoder.sv
// Byte-stuffing frame encoder with XOR checksum.
// Input queue side: drive data_byte/frame_last with push; a word is taken when
// push is high and full is low. Bytes of a frame follow one another; the first
// passes unescaped, later ones equal to any framing code get an escape prefix.
// After a word flagged frame_last the block appends the checksum (escaped the
// same way) and the stop code.
// Output queue side: while empty is low the oldest line byte is on the output
// ports; pop takes it. run_last marks the final word caused by one input word,
// frame_end marks the stop code.
// Config: cfg_index 0/1/2 selects start/stop/escape code, written when valid
// and ready are high; ready is always high. Write only while idle.
// A pushed word passes the queue and the output register before its first
// line byte shows. Throughput: one input word per cycle when each yields one
// line byte and pop keeps up; the back sequencer emits one line byte per
// cycle while pop frees the output register, so escapes and trailers (up to
// 5 bytes per word) fill the 4-entry command queue and raise full. Reset:
// codes return to 125/126/127, checksum clears, queues empty. A stalled
// receiver holds the output register; the queue keeps accepting until full.
module escaped_frame_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_line_byte,
    output logic       o_run_last,
    output logic       o_frame_end,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    efe_pkg::t_cmd    cmd;
    efe_pkg::t_cmd    head;
    efe_pkg::t_codes  codes;
    efe_pkg::t_qstat  qstat;
    logic             accept;
    logic             q_rd;

    assign o_cfg_ready = 1'b1;
    assign full        = qstat.full;
    assign accept      = push && !qstat.full;

    efe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_frame_last (i_frame_last),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cmd        (cmd),
        .o_codes      (codes)
    );

    efe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_cmd   (cmd),
        .i_rd    (q_rd),
        .o_head  (head),
        .o_stat  (qstat)
    );

    efe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_qstat     (qstat),
        .i_codes     (codes),
        .o_q_rd      (q_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_line_byte (o_line_byte),
        .o_run_last  (o_run_last),
        .o_frame_end (o_frame_end)
    );

    // stop code always closes an input word's run
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_end) |-> o_run_last)
        else $error("frame_end without run_last");

    // stop word carries the configured stop code
    a_end_is_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_end) |-> (o_line_byte == codes.stop_code))
        else $error("frame_end word is not the stop code");

    // nothing to deliver right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (empty && !full))
        else $error("output not empty after reset");

    // queue never read while empty
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_rd |-> !qstat.empty)
        else $error("command queue read while empty");

endmodule
